@@ rtl/s2af_pkg.sv @@
// shared types and constants for the sample to ascii frame block
`default_nettype none

package s2af_pkg;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET = 8'd1;

    // register reset values
    localparam logic [11:0] GAIN_RESET   = 12'd1864;
    localparam logic [11:0] OFFSET_RESET = 12'd103;

    // scaling and position limits
    localparam int unsigned SCALE_SHIFT = 12;
    localparam int unsigned POS_W       = 14;
    localparam logic [POS_W-1:0] POS_MAX = 14'd9999;

    // frame bytes
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] LINE_FEED  = 8'h0A;
    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_GT    = 8'h3E;

    // byte positions inside a frame
    localparam logic [2:0] BYTE_OPEN  = 3'd0;
    localparam logic [2:0] BYTE_THOU  = 3'd1;
    localparam logic [2:0] BYTE_POINT = 3'd2;
    localparam logic [2:0] BYTE_HUND  = 3'd3;
    localparam logic [2:0] BYTE_TENS  = 3'd4;
    localparam logic [2:0] BYTE_UNITS = 3'd5;
    localparam logic [2:0] BYTE_CLOSE = 3'd6;
    localparam logic [2:0] BYTE_LF    = 3'd7;

    // four decimal digits of one position
    typedef struct packed {
        logic [3:0] thou;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] units;
    } digits_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // leading digit of val for a decimal place weight, val below ten weights
    function automatic logic [3:0] lead_digit(input logic [POS_W-1:0] val,
                                              input logic [POS_W-1:0] weight);
        logic [3:0] d;
        d = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (val >= POS_W'(k) * weight) begin
                d = 4'(k);
            end
        end
        return d;
    endfunction

    // remainder after taking off the leading digit
    function automatic logic [POS_W-1:0] digit_rem(input logic [POS_W-1:0] val,
                                                   input logic [3:0] d,
                                                   input logic [POS_W-1:0] weight);
        return val - POS_W'(d) * weight;
    endfunction

endpackage

`default_nettype wire

@@ rtl/s2af_front.sv @@
// front: config registers, scaling and digit split pipeline
`default_nettype none

module s2af_front #(
    parameter int unsigned SAMPLE_BITS = 12
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [s2af_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [11:0]                       cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [SAMPLE_BITS-1:0]            in_sample,
    input  wire s2af_pkg::queue_stat_t             q_stat,
    output logic                                   push,
    output s2af_pkg::digits_t                      push_digits
);

    localparam int unsigned PROD_W = SAMPLE_BITS + 12;
    localparam int unsigned SUM_W  =
        ((SAMPLE_BITS > s2af_pkg::POS_W) ? SAMPLE_BITS : s2af_pkg::POS_W) + 1;

    logic [11:0] gain_reg;
    logic [11:0] offset_reg;

    logic                            v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [PROD_W-1:0]               prod1_reg;
    logic [s2af_pkg::POS_W-1:0]      pos2_reg;
    logic [3:0]                      thou3_reg, thou4_reg, thou5_reg;
    logic [9:0]                      rem3_reg;
    logic [3:0]                      hund4_reg, hund5_reg;
    logic [6:0]                      rem4_reg;
    logic [3:0]                      tens5_reg, units5_reg;

    logic                            en;
    logic [SUM_W-1:0]                sum;
    logic [s2af_pkg::POS_W-1:0]      pos_next;
    logic [3:0]                      thou_next, hund_next, tens_next;
    logic [s2af_pkg::POS_W-1:0]      rem3_full, rem4_full, rem5_full;

    // config registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= s2af_pkg::GAIN_RESET;
            offset_reg <= s2af_pkg::OFFSET_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                s2af_pkg::REG_GAIN:   gain_reg   <= cfg_data;
                s2af_pkg::REG_OFFSET: offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipeline holds while the last stage waits on a full queue
    assign en       = !(v5_reg && q_stat.full);
    assign in_ready = en;
    assign push     = v5_reg && !q_stat.full;
    assign push_digits = '{thou: thou5_reg, hund: hund5_reg,
                           tens: tens5_reg, units: units5_reg};

    // scale, offset and saturate
    always_comb begin
        sum = SUM_W'(prod1_reg[PROD_W-1:s2af_pkg::SCALE_SHIFT]) + SUM_W'(offset_reg);
        if (sum > SUM_W'(s2af_pkg::POS_MAX)) begin
            pos_next = s2af_pkg::POS_MAX;
        end else begin
            pos_next = sum[s2af_pkg::POS_W-1:0];
        end
    end

    // one decimal digit per stage, the last stage gives tens and units
    always_comb begin
        thou_next = s2af_pkg::lead_digit(pos2_reg, 14'd1000);
        rem3_full = s2af_pkg::digit_rem(pos2_reg, thou_next, 14'd1000);
        hund_next = s2af_pkg::lead_digit(14'(rem3_reg), 14'd100);
        rem4_full = s2af_pkg::digit_rem(14'(rem3_reg), hund_next, 14'd100);
        tens_next = s2af_pkg::lead_digit(14'(rem4_reg), 14'd10);
        rem5_full = s2af_pkg::digit_rem(14'(rem4_reg), tens_next, 14'd10);
    end

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (en) begin
            prod1_reg  <= PROD_W'(gain_reg) * PROD_W'(in_sample);
            pos2_reg   <= pos_next;
            thou3_reg  <= thou_next;
            rem3_reg   <= rem3_full[9:0];
            thou4_reg  <= thou3_reg;
            hund4_reg  <= hund_next;
            rem4_reg   <= rem4_full[6:0];
            thou5_reg  <= thou4_reg;
            hund5_reg  <= hund4_reg;
            tens5_reg  <= tens_next;
            units5_reg <= rem5_full[3:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/s2af_queue.sv @@
// digit queue between front and back
`default_nettype none

module s2af_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire s2af_pkg::digits_t     push_digits,
    input  wire logic                  pop,
    output s2af_pkg::digits_t          pop_digits,
    output s2af_pkg::queue_stat_t      q_stat
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    s2af_pkg::digits_t  entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_digits   = entry_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_digits;
        end
    end

endmodule

`default_nettype wire

@@ rtl/s2af_back.sv @@
// back: frame serializer with output register
`default_nettype none

module s2af_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire s2af_pkg::queue_stat_t q_stat,
    input  wire s2af_pkg::digits_t     pop_digits,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,
    output logic                       m_tlast
);

    s2af_pkg::digits_t cur_reg;
    logic [2:0]        idx_reg;
    logic              tvalid_reg;
    logic [7:0]        tdata_reg;
    logic              tlast_reg;

    logic              slot_free;
    logic              emit;
    logic [7:0]        byte_next;

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

    // a frame starts only with a queued entry, later bytes need just the slot
    assign slot_free = !tvalid_reg || m_tready;
    assign pop       = slot_free && (idx_reg == s2af_pkg::BYTE_OPEN) && !q_stat.empty;
    assign emit      = slot_free && ((idx_reg != s2af_pkg::BYTE_OPEN) || !q_stat.empty);

    // byte select
    always_comb begin
        case (idx_reg)
            s2af_pkg::BYTE_OPEN:  byte_next = s2af_pkg::CHAR_LT;
            s2af_pkg::BYTE_THOU:  byte_next = s2af_pkg::ASCII_ZERO + 8'(cur_reg.thou);
            s2af_pkg::BYTE_POINT: byte_next = s2af_pkg::CHAR_DOT;
            s2af_pkg::BYTE_HUND:  byte_next = s2af_pkg::ASCII_ZERO + 8'(cur_reg.hund);
            s2af_pkg::BYTE_TENS:  byte_next = s2af_pkg::ASCII_ZERO + 8'(cur_reg.tens);
            s2af_pkg::BYTE_UNITS: byte_next = s2af_pkg::ASCII_ZERO + 8'(cur_reg.units);
            s2af_pkg::BYTE_CLOSE: byte_next = s2af_pkg::CHAR_GT;
            default:              byte_next = s2af_pkg::LINE_FEED;
        endcase
    end

    // control: byte index and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= s2af_pkg::BYTE_OPEN;
            tvalid_reg <= 1'b0;
        end else begin
            if (emit) begin
                idx_reg    <= idx_reg + 3'd1;
                tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= pop_digits;
        end
        if (emit) begin
            tdata_reg <= byte_next;
            tlast_reg <= (idx_reg == s2af_pkg::BYTE_LF);
        end
    end

`ifndef SYNTHESIS
    // the marked byte is the line feed
    a_last_is_lf: assert property (@(posedge aclk) disable iff (!aresetn)
        tvalid_reg && tlast_reg |-> tdata_reg == s2af_pkg::LINE_FEED)
        else $error("last byte is not a line feed");

    // a finished frame leaves the index wrapped to the opening byte
    a_last_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        tvalid_reg && tlast_reg |-> idx_reg == s2af_pkg::BYTE_OPEN)
        else $error("byte index not wrapped after last byte");

    // a new frame is only started from a queued entry
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty && idx_reg == s2af_pkg::BYTE_OPEN)
        else $error("frame started without queued digits");
`endif

endmodule

`default_nettype wire

@@ rtl/sample_to_ascii_frame_top.sv @@
// top level of the sample to ascii frame block
//
// One converter sample comes in on the s_ channel; for each one an 8-byte
// ascii frame "<d.ddd>" plus a line feed leaves on the m_ channel, one byte a
// request, with m_tlast on the line feed. The value printed is
// floor(gain * sample / 4096) + offset, saturated at 9999.
// gain and offset are written through the cfg_ channel (index 0 and 1, other
// indexes ignored); cfg_ready is always high. Write them only while idle.
// The first byte of a frame passes the five pipeline stages, the queue and the
// output register after the sample is accepted.
// Throughput: the serializer sends one byte a cycle while m_tready is high;
// the front takes a sample every cycle until the digit queue
// (QUEUE_DEPTH frames) fills, then s_tready drops.
// When the receiver stalls, the output byte holds, the serializer stops and the
// queue and front back up in turn. Synchronous reset clears the pipeline, the
// queue and the output, and loads gain 1864 and offset 103.
`default_nettype none

module sample_to_ascii_frame_top #(
    parameter int unsigned SAMPLE_BITS = 12,
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [s2af_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [11:0]                         cfg_data,
    // sample input
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // sample, zero pad
    // frame output
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [7:0]                               m_tdata,  // char_out
    output logic                                     m_tlast   // last
);

    s2af_pkg::queue_stat_t q_stat;
    s2af_pkg::digits_t     push_digits;
    s2af_pkg::digits_t     pop_digits;
    logic                  push;
    logic                  pop;

    s2af_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_sample   (s_tdata[SAMPLE_BITS-1:0]),
        .q_stat      (q_stat),
        .push        (push),
        .push_digits (push_digits)
    );

    s2af_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_digits (push_digits),
        .pop         (pop),
        .pop_digits  (pop_digits),
        .q_stat      (q_stat)
    );

    s2af_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_stat     (q_stat),
        .pop_digits (pop_digits),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
